// ----- hdl/chi_pkg.sv -----
// ----------------------------------------------------------------------------
// chi_pkg
// shared types and constants for the chained hash index
// ----------------------------------------------------------------------------
`default_nettype none

package chi_pkg;

    localparam int MAX_BUCKETS  = 1024;
    localparam int POOL_ENTRIES = 4096;
    localparam int TAG_BITS     = 32;

    localparam int BKT_AW  = $clog2(MAX_BUCKETS);
    localparam int POOL_AW = $clog2(POOL_ENTRIES);
    localparam int LINK_W  = 16;
    localparam int NB_W    = 11;
    localparam int CNT_W   = 13;

    localparam logic [LINK_W-1:0] NULL_LINK = '1;
    localparam logic [NB_W-1:0]   NB_RESET  = NB_W'(MAX_BUCKETS);

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_COUNT  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_POOL_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic                valid;
        logic [TAG_BITS-1:0] tag;
        logic [31:0]         loc;
        logic [7:0]          hits;
        logic [LINK_W-1:0]   next;
    } entry_t;

    function automatic logic in_pool(input logic [LINK_W-1:0] link);
        in_pool = (32'(link) < 32'(POOL_ENTRIES));
    endfunction

endpackage

`default_nettype wire

// ----- hdl/chained_hash_index_with_free_list.sv -----
// ----------------------------------------------------------------------------
// chained_hash_index_with_free_list
// hash index with chained buckets in a fixed entry pool and a free list
// ----------------------------------------------------------------------------
// the serial modulo and the one-entry-per-cycle chain walk over the pool
//   memory read port set the transaction time; one transaction at a time
// after reset busy stays high while the head table is swept
// done pulses one cycle with the result; the receiver cannot stall
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_index_with_free_list (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [1:0]                opcode,
    input  wire logic [31:0]               set_bucket,
    input  wire logic [31:0]               tag,
    input  wire logic [31:0]               partition_offset,
    input  wire logic [7:0]                hits_in,
    input  wire logic                      count_hit,
    output logic                           done,
    output logic [1:0]                     status,
    output logic                           found,
    output logic [31:0]                    offset_out,
    output logic [7:0]                     hit_count,
    output logic [12:0]                    entry_count,
    input  wire logic                      cfg_we,
    input  wire logic [chi_pkg::NB_W-1:0]  cfg_data
);
    import chi_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DIV, S_HEAD, S_HDAT, S_EDAT, S_END, S_FREE
    } state_t;
    localparam state_t S_LINK_ST = S_FREE;

    // pending-step flag; relink shares S_FREE with the free-list pop
    typedef enum logic {
        L_NONE, L_PEND
    } link_t;

    state_t              state_reg, state_next;
    link_t               lnk_reg, lnk_next;
    logic [BKT_AW-1:0]   clr_reg, clr_next;
    logic [NB_W-1:0]     nb_reg;
    logic [NB_W-1:0]     nb_eff;
    op_t                 op_reg, op_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [31:0]         loc_reg, loc_next;
    logic [31:0]         sb_reg, sb_next;
    logic [7:0]          hin_reg, hin_next;
    logic                bump_reg, bump_next;
    logic [BKT_AW-1:0]   bkt_reg, bkt_next;
    logic [LINK_W-1:0]   cur_reg, cur_next;
    logic [LINK_W-1:0]   prev_reg, prev_next;
    logic                phead_reg, phead_next;
    entry_t              pdat_reg, pdat_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [LINK_W-1:0]   fh_reg, fh_next;
    logic [LINK_W-1:0]   hw_reg, hw_next;
    logic [LINK_W-1:0]   link_reg, link_next;

    logic                done_reg, done_next;
    status_t             status_reg, status_next;
    logic                found_reg, found_next;
    logic [31:0]         off_reg, off_next;
    logic [7:0]          hc_reg, hc_next;
    logic [CNT_W-1:0]    ec_reg, ec_next;

    // memory ports
    logic                head_we;
    logic [BKT_AW-1:0]   head_waddr, head_raddr;
    logic [LINK_W-1:0]   head_wdata, head_rdata;
    logic                pool_we;
    logic [POOL_AW-1:0]  pool_waddr, pool_raddr;
    entry_t              pool_wdata, pool_rdata;

    logic                mod_start, mod_done;
    logic [BKT_AW-1:0]   mod_rem;

    entry_t              e;
    entry_t              new_ent;
    logic                tag_hit;
    logic                can_bump;

    // out-of-range bucket counts clamp to 1..MAX_BUCKETS
    always_comb
    begin
        if (nb_reg == '0)
            nb_eff = NB_W'(1);
        else if (32'(nb_reg) > 32'(MAX_BUCKETS))
            nb_eff = NB_W'(MAX_BUCKETS);
        else
            nb_eff = nb_reg;
    end

    chi_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (sb_reg),
        .divisor  (nb_eff),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    chi_head_mem u_head (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    chi_pool_mem u_pool (
        .clk   (clk),
        .we    (pool_we),
        .waddr (pool_waddr),
        .wdata (pool_wdata),
        .raddr (pool_raddr),
        .rdata (pool_rdata)
    );

    assign e        = pool_rdata;
    assign tag_hit  = e.valid && (e.tag == tag_reg);
    assign can_bump = bump_reg && (e.hits != 8'hFF);

    always_comb
    begin
        new_ent.valid = 1'b1;
        new_ent.tag   = tag_reg;
        new_ent.loc   = loc_reg;
        new_ent.hits  = hin_reg;
        new_ent.next  = NULL_LINK;
    end

    always_comb
    begin
        state_next  = state_reg;
        lnk_next    = L_NONE;
        clr_next    = clr_reg;
        op_next     = op_reg;
        tag_next    = tag_reg;
        loc_next    = loc_reg;
        sb_next     = sb_reg;
        hin_next    = hin_reg;
        bump_next   = bump_reg;
        bkt_next    = bkt_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        phead_next  = phead_reg;
        pdat_next   = pdat_reg;
        cnt_next    = cnt_reg;
        fh_next     = fh_reg;
        hw_next     = hw_reg;
        link_next   = link_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        found_next  = found_reg;
        off_next    = off_reg;
        hc_next     = hc_reg;
        ec_next     = ec_reg;

        mod_start   = 1'b0;
        head_we     = 1'b0;
        head_waddr  = bkt_reg;
        head_wdata  = NULL_LINK;
        head_raddr  = bkt_reg;
        pool_we     = 1'b0;
        pool_waddr  = cur_reg[POOL_AW-1:0];
        pool_wdata  = e;
        pool_raddr  = cur_reg[POOL_AW-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                // sweep every bucket head to the null link
                head_we    = 1'b1;
                head_waddr = clr_reg;
                clr_next   = clr_reg + BKT_AW'(1);
                if (clr_reg == '1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = op_t'(opcode);
                    sb_next    = set_bucket;
                    tag_next   = TAG_BITS'(tag);
                    loc_next   = partition_offset;
                    hin_next   = hits_in;
                    bump_next  = count_hit;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                mod_start  = 1'b1;
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                // wait for the remainder, then read the head
                if (mod_done)
                begin
                    bkt_next   = mod_rem;
                    state_next = S_HDAT;
                end
            end
            S_HDAT:
            begin
                if (lnk_reg == L_PEND)
                begin
                    // head read data is back
                    cur_next   = head_rdata;
                    phead_next = 1'b1;
                    pool_raddr = head_rdata[POOL_AW-1:0];
                    if (in_pool(head_rdata))
                        state_next = S_EDAT;
                    else
                        state_next = S_END;
                end
                else
                begin
                    head_raddr = bkt_reg;
                    lnk_next   = L_PEND;
                end
            end
            S_EDAT:
            begin
                if (op_reg == OP_COUNT)
                    cnt_next = cnt_reg + CNT_W'(e.valid);
                if (op_reg == OP_LOOKUP && tag_hit)
                begin
                    pool_wdata      = e;
                    pool_wdata.hits = can_bump ? e.hits + 8'd1 : e.hits;
                    pool_we         = can_bump;
                    done_next       = 1'b1;
                    status_next     = ST_OK;
                    found_next      = 1'b1;
                    off_next        = e.loc;
                    hc_next         = pool_wdata.hits;
                    ec_next         = '0;
                    state_next      = S_IDLE;
                end
                else if (op_reg == OP_INSERT && tag_hit)
                begin
                    pool_wdata      = e;
                    pool_wdata.loc  = loc_reg;
                    pool_wdata.hits = hin_reg;
                    pool_we         = 1'b1;
                    done_next       = 1'b1;
                    status_next     = ST_OK;
                    found_next      = 1'b0;
                    off_next        = '0;
                    hc_next         = '0;
                    ec_next         = '0;
                    state_next      = S_IDLE;
                end
                else if (op_reg == OP_REMOVE && tag_hit && e.loc == loc_reg)
                begin
                    // free the slot onto the free list, then relink
                    pool_wdata       = e;
                    pool_wdata.valid = 1'b0;
                    pool_wdata.next  = fh_reg;
                    pool_we          = 1'b1;
                    fh_next          = cur_reg;
                    link_next        = e.next;
                    state_next       = S_LINK_ST;
                    lnk_next         = L_PEND;
                end
                else
                begin
                    prev_next  = cur_reg;
                    pdat_next  = e;
                    phead_next = 1'b0;
                    cur_next   = e.next;
                    pool_raddr = e.next[POOL_AW-1:0];
                    if (!in_pool(e.next))
                        state_next = S_END;
                end
            end
            S_END:
            begin
                found_next = 1'b0;
                off_next   = '0;
                hc_next    = '0;
                ec_next    = '0;
                pool_raddr = fh_reg[POOL_AW-1:0];
                case (op_reg)
                    OP_LOOKUP, OP_REMOVE:
                    begin
                        done_next   = 1'b1;
                        status_next = ST_NOT_FOUND;
                        state_next  = S_IDLE;
                    end
                    OP_COUNT:
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        ec_next     = cnt_reg;
                        state_next  = S_IDLE;
                    end
                    default:
                    begin
                        if (!in_pool(fh_reg))
                        begin
                            done_next   = 1'b1;
                            status_next = ST_POOL_FULL;
                            state_next  = S_IDLE;
                        end
                        else if (fh_reg == hw_reg)
                        begin
                            // take a fresh slot at the high-water mark
                            pool_we    = 1'b1;
                            pool_waddr = fh_reg[POOL_AW-1:0];
                            pool_wdata = new_ent;
                            link_next  = fh_reg;
                            fh_next    = fh_reg + LINK_W'(1);
                            hw_next    = hw_reg + LINK_W'(1);
                            state_next = S_LINK_ST;
                            lnk_next   = L_PEND;
                        end
                        else
                        begin
                            // pop the free list: read its next link first
                            state_next = S_LINK_ST;
                            lnk_next   = L_NONE;
                        end
                    end
                endcase
            end
            S_FREE:
            begin
                if (lnk_reg == L_NONE)
                begin
                    // free-list read is back
                    pool_we    = 1'b1;
                    pool_waddr = fh_reg[POOL_AW-1:0];
                    pool_wdata = new_ent;
                    link_next  = fh_reg;
                    fh_next    = e.next;
                    lnk_next   = L_PEND;
                end
                else
                begin
                    // relink predecessor or bucket head
                    if (phead_reg)
                    begin
                        head_we    = 1'b1;
                        head_wdata = link_reg;
                    end
                    else
                    begin
                        pool_we         = 1'b1;
                        pool_waddr      = prev_reg[POOL_AW-1:0];
                        pool_wdata      = pdat_reg;
                        pool_wdata.next = link_reg;
                    end
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    found_next  = 1'b0;
                    off_next    = '0;
                    hc_next     = '0;
                    ec_next     = '0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            lnk_reg    <= L_NONE;
            clr_reg    <= '0;
            nb_reg     <= NB_RESET;
            fh_reg     <= '0;
            hw_reg     <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            found_reg  <= 1'b0;
            off_reg    <= '0;
            hc_reg     <= '0;
            ec_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            lnk_reg    <= lnk_next;
            clr_reg    <= clr_next;
            if (cfg_we)
                nb_reg <= cfg_data;
            fh_reg     <= fh_next;
            hw_reg     <= hw_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            found_reg  <= found_next;
            off_reg    <= off_next;
            hc_reg     <= hc_next;
            ec_reg     <= ec_next;
        end
    end

    // transaction payload and walk pointers
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        tag_reg   <= tag_next;
        loc_reg   <= loc_next;
        sb_reg    <= sb_next;
        hin_reg   <= hin_next;
        bump_reg  <= bump_next;
        bkt_reg   <= bkt_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        phead_reg <= phead_next;
        pdat_reg  <= pdat_next;
        cnt_reg   <= cnt_next;
        link_reg  <= link_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign offset_out  = off_reg;
    assign hit_count   = hc_reg;
    assign entry_count = ec_reg;

endmodule

`default_nettype wire

// ----- hdl/chi_mod_unit.sv -----
// ----------------------------------------------------------------------------
// chi_mod_unit
// bit-serial restoring remainder of set bucket by bucket count
// ----------------------------------------------------------------------------
`default_nettype none

module chi_mod_unit (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [31:0]              dividend,
    input  wire logic [chi_pkg::NB_W-1:0] divisor,
    output logic                          done,
    output logic [chi_pkg::BKT_AW-1:0]    rem
);
    import chi_pkg::*;

    logic [31:0]     dvd_reg, dvd_next;
    logic [NB_W-1:0] rem_reg, rem_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic            run_reg, run_next;
    logic            done_reg, done_next;
    logic [NB_W:0]   trial;

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[31]};
        if (start)
        begin
            dvd_next = dividend;
            rem_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            // one quotient bit per cycle
            if (trial >= {1'b0, divisor})
                rem_next = NB_W'(trial - {1'b0, divisor});
            else
                rem_next = trial[NB_W-1:0];
            dvd_next = {dvd_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg[BKT_AW-1:0];

endmodule

`default_nettype wire

// ----- hdl/chi_head_mem.sv -----
// ----------------------------------------------------------------------------
// chi_head_mem
// bucket head table, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module chi_head_mem (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [chi_pkg::BKT_AW-1:0] waddr,
    input  wire logic [chi_pkg::LINK_W-1:0] wdata,
    input  wire logic [chi_pkg::BKT_AW-1:0] raddr,
    output logic [chi_pkg::LINK_W-1:0]      rdata
);
    import chi_pkg::*;

    logic [LINK_W-1:0] mem [MAX_BUCKETS];
    logic [LINK_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hdl/chi_pool_mem.sv -----
// ----------------------------------------------------------------------------
// chi_pool_mem
// entry pool, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module chi_pool_mem (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [chi_pkg::POOL_AW-1:0] waddr,
    input  wire chi_pkg::entry_t             wdata,
    input  wire logic [chi_pkg::POOL_AW-1:0] raddr,
    output chi_pkg::entry_t                  rdata
);
    import chi_pkg::*;

    entry_t mem [POOL_ENTRIES];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hdl/chi_checker.sv -----
// ----------------------------------------------------------------------------
// chi_checker
// port-level checks on the hash index, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module chi_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [1:0]  status,
    input wire logic        found,
    input wire logic [12:0] entry_count
);
    import chi_pkg::*;

    // a transaction keeps the block busy until its result
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    // result comes out as the block goes idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && found |-> status == ST_OK && entry_count == '0)
        else $error("found with bad status or count");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status == ST_OK || status == ST_NOT_FOUND || status == ST_POOL_FULL)
        else $error("undefined status code");

endmodule

bind chained_hash_index_with_free_list chi_checker u_chi_checker (.*);

`default_nettype wire

// ----- dv/chained_hash_index_with_free_list_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chained_hash_index_with_free_list_tb
// self-checking bench: directed table, then random phases over several bucket
// counts; each result is checked against a hand-written response from the
// table or a behavioral model of the chained index kept inside the bench
`default_nettype none

module chained_hash_index_with_free_list_tb;

    import chi_pkg::*;

    typedef struct {
        op_t         op;
        logic [31:0] sb;
        logic [31:0] tg;
        logic [31:0] off;
        logic [7:0]  hin;
        logic        bump;
    } txn_t;

    typedef struct {
        status_t     st;
        logic        fnd;
        logic [31:0] off;
        logic [7:0]  hc;
        logic [12:0] cnt;
    } rsp_t;

    // directed row: transaction plus an optional hand-written response
    typedef struct {
        txn_t t;
        bit   typed;
        rsp_t r;
    } row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          opcode;
    logic [31:0]         set_bucket;
    logic [31:0]         tag;
    logic [31:0]         partition_offset;
    logic [7:0]          hits_in;
    logic                count_hit;
    logic                done;
    logic [1:0]          status;
    logic                found;
    logic [31:0]         offset_out;
    logic [7:0]          hit_count;
    logic [12:0]         entry_count;
    logic                cfg_we;
    logic [NB_W-1:0]     cfg_data;

    chained_hash_index_with_free_list i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .opcode           (opcode),
        .set_bucket       (set_bucket),
        .tag              (tag),
        .partition_offset (partition_offset),
        .hits_in          (hits_in),
        .count_hit        (count_hit),
        .done             (done),
        .status           (status),
        .found            (found),
        .offset_out       (offset_out),
        .hit_count        (hit_count),
        .entry_count      (entry_count),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------
    // index model: head table, entry pool, free list, high-water mark
    // ------------------------------------------------------------------
    logic [LINK_W-1:0] mdl_head [MAX_BUCKETS];
    logic              mdl_valid [POOL_ENTRIES];
    logic [31:0]       mdl_tag [POOL_ENTRIES];
    logic [31:0]       mdl_loc [POOL_ENTRIES];
    logic [7:0]        mdl_hits [POOL_ENTRIES];
    logic [LINK_W-1:0] mdl_next [POOL_ENTRIES];
    logic [LINK_W-1:0] mdl_free;
    logic [LINK_W-1:0] mdl_hwm;
    logic [NB_W-1:0]   mdl_nb;

    rsp_t pending_rsp [$];
    int   errors;

    function automatic void index_clear();
        for (int i = 0; i < MAX_BUCKETS; i++)
            mdl_head[i] = NULL_LINK;
        for (int i = 0; i < POOL_ENTRIES; i++)
        begin
            mdl_valid[i] = 1'b0;
            mdl_tag[i]   = '0;
            mdl_loc[i]   = '0;
            mdl_hits[i]  = '0;
            mdl_next[i]  = '0;
        end
        mdl_free = '0;
        mdl_hwm  = '0;
        mdl_nb   = NB_RESET;
    endfunction

    function automatic bit link_ok(input logic [LINK_W-1:0] l);
        return 32'(l) < 32'(POOL_ENTRIES);
    endfunction

    function automatic rsp_t index_apply(input txn_t t);
        rsp_t        r;
        int unsigned nb;
        int unsigned b;
        logic [LINK_W-1:0] prev;
        logic [LINK_W-1:0] cur;
        logic [LINK_W-1:0] slot;
        logic [LINK_W-1:0] after;
        int unsigned steps;
        bit          hit;
        r = '{ST_OK, 1'b0, 32'd0, 8'd0, 13'd0};
        // bucket count of zero acts as one, above the table acts as the table
        nb = (mdl_nb == 0) ? 1 : ((mdl_nb > MAX_BUCKETS) ? MAX_BUCKETS : mdl_nb);
        b = t.sb % nb;
        prev = NULL_LINK;
        cur = mdl_head[b];
        steps = 0;
        hit = 1'b0;
        while (link_ok(cur) && steps < POOL_ENTRIES && !hit)
        begin
            steps++;
            if (t.op == OP_COUNT)
            begin
                if (mdl_valid[cur])
                    r.cnt++;
            end
            else if (mdl_valid[cur] && mdl_tag[cur] == t.tg)
            begin
                if (t.op == OP_LOOKUP)
                begin
                    if (t.bump && mdl_hits[cur] != 8'hFF)
                        mdl_hits[cur]++;
                    r.fnd = 1'b1;
                    r.off = mdl_loc[cur];
                    r.hc  = mdl_hits[cur];
                    hit = 1'b1;
                end
                else if (t.op == OP_INSERT)
                begin
                    mdl_loc[cur]  = t.off;
                    mdl_hits[cur] = t.hin;
                    hit = 1'b1;
                end
                else if (mdl_loc[cur] == t.off)
                begin
                    // unlink and push the slot on the free list
                    after = mdl_next[cur];
                    mdl_valid[cur] = 1'b0;
                    mdl_next[cur] = mdl_free;
                    mdl_free = cur;
                    if (prev == NULL_LINK)
                        mdl_head[b] = after;
                    else
                        mdl_next[prev] = after;
                    hit = 1'b1;
                end
            end
            if (!hit)
            begin
                prev = cur;
                cur = mdl_next[cur];
            end
        end
        if (!hit)
        begin
            if (t.op == OP_LOOKUP || t.op == OP_REMOVE)
                r.st = ST_NOT_FOUND;
            else if (t.op == OP_INSERT)
            begin
                if (!link_ok(mdl_free))
                    r.st = ST_POOL_FULL;
                else
                begin
                    slot = mdl_free;
                    if (mdl_free == mdl_hwm)
                    begin
                        mdl_free++;
                        mdl_hwm++;
                    end
                    else
                        mdl_free = mdl_next[slot];
                    mdl_next[slot]  = NULL_LINK;
                    mdl_tag[slot]   = t.tg;
                    mdl_loc[slot]   = t.off;
                    mdl_hits[slot]  = t.hin;
                    mdl_valid[slot] = 1'b1;
                    if (prev == NULL_LINK)
                        mdl_head[b] = slot;
                    else
                        mdl_next[prev] = slot;
                end
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checker: each done strobe against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t result with no transaction pending: status %h", $realtime, status);
                errors++;
            end
            else
            begin
                e = pending_rsp.pop_front();
                if (status !== e.st)
                begin
                    $display("%0t status: exp %h act %h", $realtime, e.st, status);
                    errors++;
                end
                if (found !== e.fnd)
                begin
                    $display("%0t found: exp %h act %h", $realtime, e.fnd, found);
                    errors++;
                end
                if (offset_out !== e.off)
                begin
                    $display("%0t offset_out: exp %h act %h", $realtime, e.off, offset_out);
                    errors++;
                end
                if (hit_count !== e.hc)
                begin
                    $display("%0t hit_count: exp %h act %h", $realtime, e.hc, hit_count);
                    errors++;
                end
                if (entry_count !== e.cnt)
                begin
                    $display("%0t entry_count: exp %h act %h", $realtime, e.cnt, entry_count);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    // one transaction; optional random gap first, accepted when busy is low
    task automatic send_txn(input txn_t t, input bit gaps, input bit typed, input rsp_t tr);
        rsp_t r;
        if (gaps && $urandom_range(0, 99) < 26)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
        @(negedge clk);
        opcode           <= t.op;
        set_bucket       <= t.sb;
        tag              <= t.tg;
        partition_offset <= t.off;
        hits_in          <= t.hin;
        count_hit        <= t.bump;
        start            <= 1'b1;
        do @(posedge clk); while (busy);
        r = index_apply(t);
        pending_rsp.push_back(typed ? tr : r);
    endtask

    // lower start and wait out every pending result plus settling time
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    // bucket count write, only with the block idle
    task automatic set_buckets(input logic [NB_W-1:0] v);
        drain();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        mdl_nb = v;
    endtask

    // mostly small tags, offsets and buckets so updates and removes hit
    function automatic txn_t rand_txn();
        txn_t t;
        int unsigned w;
        w = $urandom_range(0, 99);
        t.op = (w < 35) ? OP_INSERT : (w < 65) ? OP_LOOKUP : (w < 85) ? OP_REMOVE : OP_COUNT;
        t.sb  = ($urandom_range(0, 9) < 7) ? 32'($urandom_range(0, 15)) : $urandom;
        t.tg  = ($urandom_range(0, 9) < 8) ? 32'($urandom_range(0, 40)) : $urandom;
        t.off = ($urandom_range(0, 19) < 17) ? 32'($urandom_range(0, 3)) * 32'h4080_1021
                                              : $urandom;
        t.hin  = 8'($urandom);
        t.bump = 1'($urandom);
        return t;
    endfunction

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------
    localparam rsp_t R_MISS = '{ST_NOT_FOUND, 1'b0, 32'd0, 8'd0, 13'd0};
    localparam rsp_t R_OK   = '{ST_OK, 1'b0, 32'd0, 8'd0, 13'd0};

    row_t dir_tbl [] = '{
        // empty index after reset
        '{'{OP_LOOKUP, 32'd0, 32'd0, 32'd0, 8'd0, 1'b1}, 1'b1, R_MISS},
        '{'{OP_COUNT, 32'hFFFF_FFFF, 32'd0, 32'd0, 8'd0, 1'b0}, 1'b1, R_OK},
        '{'{OP_REMOVE, 32'd0, 32'd0, 32'd0, 8'd0, 1'b0}, 1'b1, R_MISS},
        // all-ones fields, hit count already saturated
        '{'{OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1}, 1'b1, R_OK},
        '{'{OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 8'd0, 1'b1}, 1'b1,
          '{ST_OK, 1'b1, 32'hFFFF_FFFF, 8'hFF, 13'd0}},
        '{'{OP_INSERT, 32'd1023, 32'd0, 32'd0, 8'd0, 1'b0}, 1'b1, R_OK},
        '{'{OP_INSERT, 32'd1023, 32'd5, 32'h1234_5678, 8'd254, 1'b0}, 1'b1, R_OK},
        // bump up to the saturation point and past it
        '{'{OP_LOOKUP, 32'd1023, 32'd5, 32'd0, 8'd0, 1'b1}, 1'b1,
          '{ST_OK, 1'b1, 32'h1234_5678, 8'hFF, 13'd0}},
        '{'{OP_LOOKUP, 32'd1023, 32'd5, 32'd0, 8'd0, 1'b1}, 1'b1,
          '{ST_OK, 1'b1, 32'h1234_5678, 8'hFF, 13'd0}},
        '{'{OP_COUNT, 32'd1023, 32'd0, 32'd0, 8'd0, 1'b0}, 1'b1,
          '{ST_OK, 1'b0, 32'd0, 8'd0, 13'd3}},
        // update in place still gives ok
        '{'{OP_INSERT, 32'd1023, 32'd0, 32'h0000_AAAA, 8'd7, 1'b0}, 1'b1, R_OK},
        '{'{OP_LOOKUP, 32'd1023, 32'd0, 32'd0, 8'd0, 1'b0}, 1'b1,
          '{ST_OK, 1'b1, 32'h0000_AAAA, 8'd7, 13'd0}},
        // tag matches but offset does not
        '{'{OP_REMOVE, 32'd1023, 32'd0, 32'd1, 8'd0, 1'b0}, 1'b1, R_MISS},
        // unlink at head, then at tail
        '{'{OP_REMOVE, 32'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 1'b0}, 1'b1, R_OK},
        '{'{OP_COUNT, 32'd1023, 32'd0, 32'd0, 8'd0, 1'b0}, 1'b1,
          '{ST_OK, 1'b0, 32'd0, 8'd0, 13'd2}},
        '{'{OP_REMOVE, 32'd1023, 32'd5, 32'h1234_5678, 8'd0, 1'b0}, 1'b1, R_OK},
        // new entry from the free list
        '{'{OP_INSERT, 32'd1023, 32'd9, 32'h55, 8'd3, 1'b0}, 1'b0, R_OK},
        '{'{OP_LOOKUP, 32'd1023, 32'd9, 32'd0, 8'd0, 1'b0}, 1'b0, R_OK},
        '{'{OP_REMOVE, 32'd1023, 32'd0, 32'h0000_AAAA, 8'd0, 1'b0}, 1'b1, R_OK},
        '{'{OP_COUNT, 32'd1023, 32'd0, 32'd0, 8'd0, 1'b0}, 1'b1,
          '{ST_OK, 1'b0, 32'd0, 8'd0, 13'd1}},
        '{'{OP_COUNT, 32'd0, 32'd0, 32'd0, 8'd0, 1'b0}, 1'b1, R_OK},
        '{'{OP_INSERT, 32'd3, 32'h8000_0001, 32'h7FFF_FFFF, 8'h80, 1'b0}, 1'b0, R_OK},
        '{'{OP_LOOKUP, 32'd3, 32'h8000_0001, 32'd0, 8'd0, 1'b1}, 1'b0, R_OK}
    };

    logic [NB_W-1:0] phase_nb [5] = '{11'd1, 11'd0, 11'd7, 11'd2047, 11'd1024};

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        errors           = 0;
        rst_n            = 1'b0;
        start            = 1'b0;
        opcode           = '0;
        set_bucket       = '0;
        tag              = '0;
        partition_offset = '0;
        hits_in          = '0;
        count_hit        = 1'b0;
        cfg_we           = 1'b0;
        cfg_data         = '0;
        index_clear();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_tbl[i])
            send_txn(dir_tbl[i].t, 1'b1, dir_tbl[i].typed, dir_tbl[i].r);

        // random phases across bucket counts, extremes included
        for (int p = 0; p < 5; p++)
        begin
            set_buckets(phase_nb[p]);
            for (int n = 0; n < 180; n++)
            begin
                // hold off until the block has emptied out once
                if (p == 1 && n == 90)
                    drain();
                send_txn(rand_txn(), p != 2, 1'b0, R_OK);
            end
        end

        drain();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial
    begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
